// ===== hw/rtl/srpg_pkg.sv =====
// Shared types and constants for the stepper ramp pulse generator.
// Opcode and mode codes, register indexes, reset values and stream widths.
// No dependencies.
package srpg_pkg;

  // Command opcodes carried in the input tuser
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_MOVE = 2'd1,
    OP_RUN  = 2'd2,
    OP_STOP = 2'd3
  } op_e;

  // Motion modes as reported in the result
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_MOVING  = 2'd1,
    MODE_RUNNING = 2'd2
  } mode_e;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DELAY = 3'd4;

  // Register widths and reset values
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned INIT_DELAY_W = 20;
  localparam logic [SPEED_W-1:0]      ACCEL_RST = 16'd100;
  localparam logic [SPEED_W-1:0]      MIN_SPEED_RST = 16'd200;
  localparam logic [INIT_DELAY_W-1:0] INIT_DELAY_RST = 20'd2000;

  // Result stream: step_event, step_up, position, mode, padded to bytes
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OP_W = 2;

endpackage

// ===== hw/rtl/srpg_alu.sv =====
// Shared add/subtract unit of the stepper ramp pulse generator.
// Serves target mapping, distance, and the restoring divider steps.
// No dependencies.
module srpg_alu #(
  parameter int unsigned WIDTH = 51
) (
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic             sub_i,
  output logic [WIDTH-1:0] sum_o
);

  // Two's complement add, or subtract by inverting b and carrying in
  logic [WIDTH-1:0] b_eff;

  assign b_eff = sub_i ? ~b_i : b_i;
  assign sum_o = a_i + b_eff + {{(WIDTH-1){1'b0}}, sub_i};

endmodule

// ===== hw/rtl/stepper_ramp_pulse_generator.sv =====
// Stepper ramp pulse generator top level: command sequencer and state.
// Uses srpg_pkg and one shared srpg_alu adder for the target, distance and divider arithmetic.
//
//   channel   | direction | transfer condition            | payload
//   s_axis    | in        | s_axis_tvalid & s_axis_tready | command item
//   m_axis    | out       | m_axis_tvalid & m_axis_tready | one result per command
//   cfg       | in        | cfg_valid_i & cfg_ready_o     | register index and data
//
// A tick that takes a step at nonzero speed runs the serial 1/speed divider
// for DELAY_W quotient bits; DELAY_W is 20 at the default rate. A move-to
// runs the shift-add target multiply over the FRACTION_BITS+1 fraction bits.
// Reset is asynchronous, active low, and loads the register defaults.
// The next command is taken while a finished result waits on m_axis.
module stepper_ramp_pulse_generator
  import srpg_pkg::*;
#(
  parameter int unsigned FRACTION_BITS    = 16,
  parameter int unsigned TICKS_PER_SECOND = 1000000
) (
  input  logic clk_i,
  input  logic rst_ni,

  // Command stream
  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  // tdata from bit 0: target_fraction, speed_limit, run_reverse, zero pad
  input  logic [(((FRACTION_BITS+18)+7)/8)*8-1:0]       s_axis_tdata,
  // tuser: opcode
  input  logic [OP_W-1:0]                               s_axis_tuser,

  // Result stream
  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  // tdata from bit 0: step_event, step_up, position[31:0], mode[1:0], zero pad
  output logic [OUT_TDATA_W-1:0]                        m_axis_tdata,

  // Configuration writes
  input  logic                                          cfg_valid_i,
  output logic                                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]                          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]                         cfg_data_i
);

  localparam int unsigned FB      = FRACTION_BITS;
  localparam int unsigned FRAC_W  = FB + 1;
  localparam int unsigned ACC_W   = FB + 35;
  localparam int unsigned TPS_W   = $clog2(TICKS_PER_SECOND + 1);
  localparam int unsigned DELAY_W = (TPS_W < INIT_DELAY_W) ? INIT_DELAY_W : TPS_W;
  localparam int unsigned MUL_N   = FRAC_W;
  localparam int unsigned DIV_N   = DELAY_W;
  localparam int unsigned MAX_N   = (MUL_N > DIV_N) ? MUL_N : DIV_N;
  localparam int unsigned CNT_W   = $clog2(MAX_N + 1);
  localparam logic [DELAY_W-1:0] TPS_D = DELAY_W'(TICKS_PER_SECOND);

  // Sequencer states
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_TICK  = 9'b000000010,
    S_DIFF  = 9'b000000100,
    S_ABS   = 9'b000001000,
    S_SPEED = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_MDIF  = 9'b001000000,
    S_MUL   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  localparam state_e S_TGT_UNUSED = S_IDLE;

  state_e state_q;

  // Configuration registers
  logic signed [31:0]       low_q, high_q;
  logic [SPEED_W-1:0]       accel_q, min_q;

  // Motion state
  mode_e                    mode_q;
  logic [31:0]              pos_q;
  logic signed [31:0]       tgt_q;
  logic [SPEED_W-1:0]       speed_q, max_q;
  logic [DELAY_W-1:0]       delay_q;
  logic [31:0]              ticks_q;
  logic                     dir_up_q;

  // Working registers
  logic [FRAC_W-1:0]        frac_q;
  logic [ACC_W-1:0]         acc_q, mcand_q;
  logic [32:0]              diff_q;
  logic                     up_q, stepped_q, tgt_pend_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [SPEED_W-1:0]       rem_q;
  logic [DELAY_W-1:0]       quo_q;

  // Result register
  logic                     m_valid_q;
  logic [OUT_TDATA_W-1:0]   m_data_q;

  // Input field unpacking
  logic [FRAC_W-1:0]        in_frac;
  logic [SPEED_W-1:0]       in_lim;
  logic                     in_rev;
  op_e                      in_op;
  logic                     in_xfer, cfg_xfer, out_free, out_load;

  assign in_frac  = s_axis_tdata[FRAC_W-1:0];
  assign in_lim   = s_axis_tdata[FRAC_W+SPEED_W-1:FRAC_W];
  assign in_rev   = s_axis_tdata[FRAC_W+SPEED_W];
  assign in_op    = op_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == S_IDLE) && !tgt_pend_q;
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;
  assign cfg_xfer = cfg_valid_i;
  assign out_free = !m_valid_q || m_axis_tready;
  // a new result enters the output register this cycle
  assign out_load = (state_q == S_DONE) && out_free;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Shared adder operand selection
  logic [ACC_W-1:0] alu_a, alu_b, alu_sum;
  logic             alu_sub;
  logic [SPEED_W:0] rem_shift;

  assign rem_shift = {rem_q, quo_q[DELAY_W-1]};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    if (tgt_pend_q) begin
      // rounding toward zero: bias negative sums before the arithmetic shift
      alu_a = acc_q;
      alu_b = acc_q[ACC_W-1] ? {{(ACC_W-FB){1'b0}}, {FB{1'b1}}} : '0;
    end else begin
      unique case (state_q)
        S_MDIF: begin
          alu_a   = {{(ACC_W-32){high_q[31]}}, high_q};
          alu_b   = {{(ACC_W-32){low_q[31]}}, low_q};
          alu_sub = 1'b1;
        end
        S_MUL: begin
          alu_a = acc_q;
          alu_b = frac_q[0] ? mcand_q : '0;
        end
        S_DIFF: begin
          alu_a   = {{(ACC_W-32){tgt_q[31]}}, tgt_q};
          alu_b   = {{(ACC_W-32){pos_q[31]}}, pos_q};
          alu_sub = 1'b1;
        end
        S_ABS: begin
          alu_b   = {{(ACC_W-33){diff_q[32]}}, diff_q};
          alu_sub = diff_q[32];
        end
        S_DIV: begin
          alu_a   = {{(ACC_W-SPEED_W-1){1'b0}}, rem_shift};
          alu_b   = {{(ACC_W-SPEED_W){1'b0}}, speed_q};
          alu_sub = 1'b1;
        end
        default: begin
          alu_sub = 1'b0;
        end
      endcase
    end
  end

  srpg_alu #(
    .WIDTH (ACC_W)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum)
  );

  // Target saturation to the signed 32-bit range
  logic [ACC_W-FB-1:0] tgt_wide;
  logic                tgt_fits;
  logic signed [31:0]  tgt_d;

  assign tgt_wide = alu_sum[ACC_W-1:FB];
  assign tgt_fits = (&tgt_wide[ACC_W-FB-1:31]) || !(|tgt_wide[ACC_W-FB-1:31]);
  assign tgt_d    = tgt_fits ? tgt_wide[31:0]
                  : (tgt_wide[ACC_W-FB-1] ? 32'sh8000_0000 : 32'sh7fff_ffff);

  // Elapsed tick count and step due check
  logic [31:0] ticks_d;
  logic        step_due;

  assign ticks_d  = (&ticks_q) ? ticks_q : ticks_q + 32'd1;
  assign step_due = (mode_q != MODE_IDLE) &&
                    (ticks_d >= {{(32-DELAY_W){1'b0}}, delay_q});

  // Speed ramp for the step being taken
  logic [SPEED_W:0]   sp_add, sp_sub, max_plus;
  logic [SPEED_W-1:0] sp_up, speed_d;
  logic               decel, step_dir;

  assign sp_add   = {1'b0, speed_q} + {1'b0, accel_q};
  assign sp_sub   = {1'b0, speed_q} - {1'b0, accel_q};
  assign max_plus = {1'b0, max_q} + {1'b0, accel_q};
  assign sp_up    = (sp_add > {1'b0, max_q}) ? max_q : sp_add[SPEED_W-1:0];
  assign decel    = diff_q < {{(33-SPEED_W){1'b0}}, accel_q};
  assign step_dir = (mode_q == MODE_MOVING) ? up_q : dir_up_q;

  always_comb begin
    speed_d = speed_q;
    if (mode_q == MODE_MOVING) begin
      if (decel) begin
        speed_d = (sp_sub[SPEED_W] || (sp_sub[SPEED_W-1:0] < min_q))
                ? min_q : sp_sub[SPEED_W-1:0];
      end else begin
        speed_d = sp_up;
      end
    end else if (speed_q < max_q) begin
      speed_d = sp_up;
    end else if (speed_q > max_q) begin
      speed_d = ({1'b0, speed_q} < max_plus) ? max_q : sp_sub[SPEED_W-1:0];
    end
  end

  // Restoring divider step
  logic               div_ge;
  logic [DELAY_W-1:0] quo_d;

  assign div_ge = !alu_sum[ACC_W-1];
  assign quo_d  = {quo_q[DELAY_W-2:0], div_ge};

  // Sequencer and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      low_q        <= '0;
      high_q       <= '0;
      accel_q      <= ACCEL_RST;
      min_q        <= MIN_SPEED_RST;
      mode_q       <= MODE_IDLE;
      pos_q        <= '0;
      tgt_q        <= '0;
      speed_q      <= '0;
      max_q        <= '0;
      delay_q      <= DELAY_W'(INIT_DELAY_RST);
      ticks_q      <= '0;
      dir_up_q     <= 1'b1;
      frac_q       <= '0;
      acc_q        <= '0;
      mcand_q      <= '0;
      diff_q       <= '0;
      up_q         <= 1'b0;
      stepped_q    <= 1'b0;
      tgt_pend_q   <= 1'b0;
      cnt_q        <= '0;
      rem_q        <= '0;
      quo_q        <= '0;
      m_valid_q    <= 1'b0;
      m_data_q     <= '0;
    end else begin
      if (m_valid_q && m_axis_tready && !out_load) begin
        m_valid_q <= 1'b0;
      end

      if (tgt_pend_q) begin
        // finish move-to: load target, switch to moving when it changed
        tgt_pend_q <= 1'b0;
        if (tgt_d != tgt_q) begin
          tgt_q  <= tgt_d;
          mode_q <= MODE_MOVING;
        end
        state_q <= S_DONE;
      end else begin
        unique case (state_q)
          S_IDLE: begin
            if (in_xfer) begin
              stepped_q <= 1'b0;
              up_q      <= 1'b0;
              frac_q    <= in_frac;
              unique case (in_op)
                OP_TICK: state_q <= S_TICK;
                OP_MOVE: begin
                  max_q   <= in_lim;
                  state_q <= S_MDIF;
                end
                OP_RUN: begin
                  dir_up_q <= !in_rev;
                  max_q    <= in_lim;
                  mode_q   <= MODE_RUNNING;
                  state_q  <= S_DONE;
                end
                OP_STOP: begin
                  mode_q  <= MODE_IDLE;
                  state_q <= S_DONE;
                end
                default: state_q <= S_DONE;
              endcase
            end
          end
          S_TICK: begin
            if (step_due) begin
              ticks_q <= '0;
              state_q <= (mode_q == MODE_MOVING) ? S_DIFF : S_SPEED;
            end else begin
              ticks_q <= ticks_d;
              state_q <= S_DONE;
            end
          end
          S_DIFF: begin
            diff_q  <= alu_sum[32:0];
            state_q <= S_ABS;
          end
          S_ABS: begin
            if (diff_q == '0) begin
              mode_q  <= MODE_IDLE;
              state_q <= S_DONE;
            end else begin
              up_q    <= !diff_q[32];
              diff_q  <= alu_sum[32:0];
              state_q <= S_SPEED;
            end
          end
          S_SPEED: begin
            speed_q   <= speed_d;
            up_q      <= step_dir;
            stepped_q <= 1'b1;
            pos_q     <= step_dir ? pos_q + 32'd1 : pos_q - 32'd1;
            if (speed_d == '0) begin
              delay_q <= TPS_D;
              state_q <= S_DONE;
            end else begin
              rem_q   <= '0;
              quo_q   <= TPS_D;
              cnt_q   <= '0;
              state_q <= S_DIV;
            end
          end
          S_DIV: begin
            rem_q <= div_ge ? alu_sum[SPEED_W-1:0] : rem_shift[SPEED_W-1:0];
            quo_q <= quo_d;
            cnt_q <= cnt_q + CNT_W'(1);
            if (cnt_q == CNT_W'(DIV_N - 1)) begin
              delay_q <= quo_d;
              state_q <= S_DONE;
            end
          end
          S_MDIF: begin
            mcand_q <= alu_sum;
            acc_q   <= {{(ACC_W-32-FB){low_q[31]}}, low_q, {FB{1'b0}}};
            cnt_q   <= '0;
            state_q <= S_MUL;
          end
          S_MUL: begin
            acc_q   <= alu_sum;
            mcand_q <= {mcand_q[ACC_W-2:0], 1'b0};
            frac_q  <= {1'b0, frac_q[FRAC_W-1:1]};
            cnt_q   <= cnt_q + CNT_W'(1);
            if (cnt_q == CNT_W'(MUL_N - 1)) begin
              tgt_pend_q <= 1'b1;
            end
          end
          S_DONE: begin
            if (out_free) begin
              m_valid_q <= 1'b1;
              m_data_q  <= {{(OUT_TDATA_W-36){1'b0}}, mode_q, pos_q,
                            stepped_q & up_q, stepped_q};
              state_q   <= S_IDLE;
            end
          end
          default: state_q <= S_TGT_UNUSED;
        endcase
      end

      // Register writes; loading the initial delay also reloads the step delay
      if (cfg_xfer) begin
        unique case (cfg_index_i)
          REG_LOW_LIMIT:  low_q   <= cfg_data_i;
          REG_HIGH_LIMIT: high_q  <= cfg_data_i;
          REG_ACCEL_STEP: accel_q <= cfg_data_i[SPEED_W-1:0];
          REG_MIN_SPEED:  min_q   <= cfg_data_i[SPEED_W-1:0];
          REG_INITIAL_DELAY: begin
            delay_q <= DELAY_W'(cfg_data_i[INIT_DELAY_W-1:0]);
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for the stepper ramp pulse generator: command stream,
// result stream and register writes, with an in-line motion predictor.
// Depends on srpg_pkg and the stepper_ramp_pulse_generator RTL.
module tb_top;
  import srpg_pkg::*;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned TICKS_PER_S = 1000000;
  localparam int unsigned IN_TDATA_W  = (((FRAC_BITS + 18) + 7) / 8) * 8;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned N_PHASES    = 8;
  localparam longint      POS_MAX     = 64'sd2147483647;
  localparam longint      POS_MIN     = -64'sd2147483648;
  localparam int          LIMIT_MIN   = -2147483647 - 1;
  localparam int          LIMIT_MAX   = 2147483647;
  localparam logic [CFG_IDX_W:0] REG_FIRST_UNUSED = {1'b0, REG_INITIAL_DELAY} + 1'b1;

  typedef struct packed {
    op_e                op;
    logic [FRAC_BITS:0] frac;
    logic [15:0]        lim;
    logic               rev;
  } motor_cmd_t;

  typedef struct packed {
    logic        ev;
    logic        up;
    logic [31:0] pos;
    mode_e       mode;
  } step_result_t;

  // DUT ports
  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]        s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  // Register copies and motion state of the predictor
  int          lim_low, lim_high;
  int unsigned ramp_accel, ramp_floor;
  mode_e       mot_mode;
  logic [31:0] mot_pos, mot_ticks, mot_delay;
  int          mot_target;
  int unsigned mot_speed, mot_vmax;
  logic        mot_dir_up;

  // Stimulus and result bookkeeping
  motor_cmd_t   cmd_backlog[$];
  step_result_t result_backlog[$];
  motor_cmd_t   drv_cmd;
  step_result_t got, want;
  logic         cmd_fire = 1'b0;
  logic         idling_on = 1'b1;
  int unsigned  send_gap = 0, recv_gap = 0;
  int unsigned  n_queued = 0, n_accepted = 0, n_steps = 0, n_arrivals = 0;
  int unsigned  n_errors = 0, n_cycles = 0;

  stepper_ramp_pulse_generator #(
    .FRACTION_BITS    (FRAC_BITS),
    .TICKS_PER_SECOND (TICKS_PER_S)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Predict the result of one command and advance the motion state
  function automatic step_result_t advance_motor(motor_cmd_t c);
    step_result_t r;
    longint       cur, tgt, togo, span, num, t, s;
    int unsigned  nxt;
    r = '0;
    case (c.op)
      OP_TICK: begin
        if (mot_ticks != '1) mot_ticks = mot_ticks + 32'd1;
        if (mot_mode != MODE_IDLE && mot_ticks >= mot_delay) begin
          mot_ticks = '0;
          if (mot_mode == MODE_MOVING) begin
            cur  = longint'(signed'(mot_pos));
            tgt  = longint'(mot_target);
            togo = (tgt > cur) ? tgt - cur : cur - tgt;
            if (togo > 0) begin
              r.up = (cur < tgt);
              r.ev = 1'b1;
              // decelerate when closer than one acceleration step
              if (togo < longint'(ramp_accel)) begin
                s = longint'(mot_speed) - longint'(ramp_accel);
                if (s < longint'(ramp_floor)) s = longint'(ramp_floor);
                mot_speed = s[31:0];
              end else begin
                nxt = mot_speed + ramp_accel;
                mot_speed = (nxt > mot_vmax) ? mot_vmax : nxt;
              end
            end else begin
              mot_mode = MODE_IDLE;
              n_arrivals++;
            end
          end else begin
            // running: ramp toward the speed limit from either side
            if (mot_speed < mot_vmax) begin
              nxt = mot_speed + ramp_accel;
              mot_speed = (nxt > mot_vmax) ? mot_vmax : nxt;
            end else if (mot_speed > mot_vmax) begin
              mot_speed = (mot_speed < mot_vmax + ramp_accel) ? mot_vmax
                                                              : mot_speed - ramp_accel;
            end
            r.up = mot_dir_up;
            r.ev = 1'b1;
          end
          if (r.ev) begin
            mot_delay = (mot_speed == 0) ? TICKS_PER_S : TICKS_PER_S / mot_speed;
            mot_pos   = r.up ? mot_pos + 32'd1 : mot_pos - 32'd1;
          end
        end
      end
      OP_MOVE: begin
        span = longint'(lim_high) - longint'(lim_low);
        num  = longint'(lim_low) * (longint'(1) << FRAC_BITS) + longint'(c.frac) * span;
        t    = num / (longint'(1) << FRAC_BITS);
        if (t > POS_MAX) t = POS_MAX;
        if (t < POS_MIN) t = POS_MIN;
        if (int'(t) != mot_target) begin
          mot_target = int'(t);
          mot_mode   = MODE_MOVING;
        end
        mot_vmax = 32'(c.lim);
      end
      OP_RUN: begin
        mot_dir_up = ~c.rev;
        mot_vmax   = 32'(c.lim);
        mot_mode   = MODE_RUNNING;
      end
      default: mot_mode = MODE_IDLE;
    endcase
    r.pos  = mot_pos;
    r.mode = mot_mode;
    return r;
  endfunction

  function automatic motor_cmd_t rand_cmd(op_e op);
    motor_cmd_t c;
    c.op   = op;
    c.frac = (FRAC_BITS + 1)'($urandom_range(0, 2 ** (FRAC_BITS + 1) - 1));
    c.lim  = 16'($urandom_range(0, 65535));
    c.rev  = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic motor_cmd_t mk_cmd(op_e op, int unsigned frac, int unsigned lim,
                                        logic rev);
    motor_cmd_t c;
    c.op   = op;
    c.frac = (FRAC_BITS + 1)'(frac);
    c.lim  = 16'(lim);
    c.rev  = rev;
    return c;
  endfunction

  // Mostly fast limits so steps keep coming; zero and slow ones now and then
  function automatic logic [15:0] pick_speed_limit();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return '0;
    if (pick < 15) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(20000, 65535));
  endfunction

  task automatic queue_cmd(motor_cmd_t c);
    cmd_backlog.push_back(c);
    n_queued++;
  endtask

  // Motion sequences: mostly a command, then a train of ticks; some random commands stand alone
  task automatic queue_motion_burst(int unsigned n);
    int unsigned start, pick, k;
    motor_cmd_t  c;
    start = n_queued;
    while (n_queued - start < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        c = rand_cmd(OP_MOVE);
        c.frac = (FRAC_BITS + 1)'(($urandom_range(0, 9) != 0)
                                  ? $urandom_range(0, 2 ** FRAC_BITS)
                                  : $urandom_range(0, 2 ** (FRAC_BITS + 1) - 1));
        c.lim = pick_speed_limit();
        queue_cmd(c);
        k = $urandom_range(15, 60);
      end else if (pick < 75) begin
        c = rand_cmd(OP_RUN);
        c.lim = pick_speed_limit();
        queue_cmd(c);
        k = $urandom_range(10, 50);
      end else if (pick < 85) begin
        queue_cmd(rand_cmd(OP_STOP));
        k = $urandom_range(1, 5);
      end else begin
        queue_cmd(rand_cmd(op_e'($urandom_range(0, 3))));
        k = 0;
      end
      repeat (k) if (n_queued - start < n) queue_cmd(rand_cmd(OP_TICK));
    end
  endtask

  // One register write transfer; the predictor copy follows at the handshake
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_LOW_LIMIT:     lim_low = int'(val);
      REG_HIGH_LIMIT:    lim_high = int'(val);
      REG_ACCEL_STEP:    ramp_accel = 32'(val[15:0]);
      REG_MIN_SPEED:     ramp_floor = 32'(val[15:0]);
      REG_INITIAL_DELAY: mot_delay = 32'(val[19:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_regs(int lo, int hi, int unsigned accel, int unsigned min_v,
                              int unsigned delay_v);
    write_reg(REG_LOW_LIMIT, lo);
    write_reg(REG_HIGH_LIMIT, hi);
    write_reg(REG_ACCEL_STEP, accel);
    write_reg(REG_MIN_SPEED, min_v);
    write_reg(REG_INITIAL_DELAY, delay_v);
  endtask

  // Hold off until every command is taken and every result has come back
  task automatic wait_for_drain();
    do @(negedge clk_i); while (n_accepted != n_queued || result_backlog.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic report_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    n_errors++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
  endtask

  // Command driver: new item after each transfer, random gap bursts
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || cmd_fire)) begin
      if (send_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (cmd_backlog.size() > 0) begin
        drv_cmd = cmd_backlog.pop_front();
        s_axis_tdata  <= {{(IN_TDATA_W - FRAC_BITS - 18){1'b0}},
                          drv_cmd.rev, drv_cmd.lim, drv_cmd.frac};
        s_axis_tuser  <= drv_cmd.op;
        s_axis_tvalid <= 1'b1;
        if (idling_on && $urandom_range(0, 4) == 0) send_gap <= $urandom_range(1, 10);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result sink: ready with random stall bursts
  always @(negedge clk_i) begin
    if (recv_gap > 0) begin
      m_axis_tready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (idling_on && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 10);
    end
  end

  // Monitor: check results against the oldest prediction, predict taken commands
  always @(posedge clk_i) begin
    cmd_fire <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.ev   = m_axis_tdata[0];
      got.up   = m_axis_tdata[1];
      got.pos  = m_axis_tdata[33:2];
      got.mode = mode_e'(m_axis_tdata[35:34]);
      if (got.ev === 1'b1) n_steps++;
      if (result_backlog.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
      end else begin
        want = result_backlog.pop_front();
        if (got.ev !== want.ev) report_field("step_event", 32'(want.ev), 32'(got.ev));
        if (got.up !== want.up) report_field("step_up", 32'(want.up), 32'(got.up));
        if (got.pos !== want.pos) report_field("position", want.pos, got.pos);
        if (got.mode !== want.mode) report_field("mode", 32'(want.mode), 32'(got.mode));
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      result_backlog.push_back(advance_motor(drv_cmd));
      n_accepted++;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending", n_cycles,
               result_backlog.size());
      $display("[stepper_ramp_pulse_generator] ERROR");
      $finish;
    end
  end

  // Phases: register setting, then commands, then drain before the next setting
  initial begin : stimulus
    int     lo;
    longint hi;
    lim_low     = 0;
    lim_high    = 0;
    ramp_accel  = 32'(ACCEL_RST);
    ramp_floor  = 32'(MIN_SPEED_RST);
    mot_mode    = MODE_IDLE;
    mot_pos     = '0;
    mot_target  = 0;
    mot_speed   = 0;
    mot_vmax    = 0;
    mot_delay   = 32'(INIT_DELAY_RST);
    mot_ticks   = '0;
    mot_dir_up  = 1'b1;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      idling_on = (ph != 3) && (ph != N_PHASES - 1);
      case (ph)
        0: program_regs(LIMIT_MIN, LIMIT_MAX, 65535, 65535, 1);
        // tight span so moves reach their target; decel floor at or above every limit
        1: program_regs(-4, 4, 65535, 65535, 1);
        2: program_regs(0, 100000, 30000, 1, 20);
        3: program_regs(100, -100, 50, 50000, 1);
        // reversed extreme span, slowest ramp, longest start delay
        4: program_regs(LIMIT_MAX, LIMIT_MIN, 1, 1, 1000000);
        default: begin
          lo = ($urandom_range(0, 1) == 1) ? int'($urandom())
                                           : int'($urandom_range(0, 200)) - 100;
          hi = longint'(lo) + longint'($urandom_range(0, 300)) - 150;
          if (hi > POS_MAX) hi = POS_MAX;
          if (hi < POS_MIN) hi = POS_MIN;
          program_regs(lo, int'(hi), $urandom_range(5000, 65535),
                       $urandom_range(1000, 65535), $urandom_range(1, 50));
        end
      endcase
      if (ph == 5) begin
        // writes to unmapped indexes must leave everything alone
        for (logic [CFG_IDX_W:0] i = REG_FIRST_UNUSED; i < 2 ** CFG_IDX_W; i++)
          write_reg(i[CFG_IDX_W-1:0], $urandom());
      end

      if (ph == 0) begin
        // directed: idle tick, target at both limits, saturation, rounding to zero
        queue_cmd(rand_cmd(OP_TICK));
        queue_cmd(mk_cmd(OP_MOVE, 0, 65535, 1'b0));
        queue_cmd(rand_cmd(OP_TICK));
        queue_cmd(mk_cmd(OP_MOVE, 2 ** FRAC_BITS, 65535, 1'b1));
        queue_cmd(mk_cmd(OP_MOVE, 2 ** (FRAC_BITS + 1) - 1, 0, 1'b0));
        queue_cmd(mk_cmd(OP_MOVE, 2 ** (FRAC_BITS - 1), 65535, 1'b1));
        repeat (15) queue_cmd(rand_cmd(OP_TICK));
        queue_cmd(mk_cmd(OP_RUN, 2 ** (FRAC_BITS + 1) - 1, 0, 1'b1));
        queue_cmd(mk_cmd(OP_STOP, 0, 0, 1'b0));
        queue_cmd(mk_cmd(OP_RUN, 0, 65535, 1'b0));
        queue_cmd(rand_cmd(OP_TICK));
      end else begin
        queue_motion_burst((ph == 4) ? 30 : 135);
      end
      wait_for_drain();
    end

    repeat (40) @(posedge clk_i);
    $display("Covered %0d commands over %0d register settings: %0d steps,",
             n_accepted, N_PHASES, n_steps);
    $display("%0d target arrivals, %0d field mismatches.", n_arrivals, n_errors);
    if (n_errors == 0) begin
      $display("[stepper_ramp_pulse_generator] OK");
    end else begin
      $display("[stepper_ramp_pulse_generator] ERROR");
    end
    $finish;
  end

endmodule
